// ----- sv/cscp_pkg.sv -----
package cscp_pkg;

  localparam int MAX_COMMAND_LENGTH_DEF = 255;

  localparam logic [1:0] PH_BETWEEN = 2'd0;
  localparam logic [1:0] PH_CLASSES = 2'd1;
  localparam logic [1:0] PH_PERMS   = 2'd2;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_SET = 2'd2;

  localparam logic [8:0] MODE_MASK = 9'o777;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
    logic       last;
    logic [8:0] start_mode;
  } cmd_t;

  typedef struct packed {
    logic [8:0] new_mode;
    logic       failed;
  } res_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [8:0] class_select;
    logic [1:0] operator_code;
    logic [8:0] pending_bits;
    logic [8:0] working_mode;
  } clause_t;

  function automatic logic [8:0] fold_clause(input clause_t c);
    logic [8:0] wm;
    wm = c.working_mode;
    case (c.operator_code)
      OP_ADD:  wm = wm | c.pending_bits;
      OP_SUB:  wm = wm & ~c.pending_bits;
      default: wm = (wm & ~c.class_select) | c.pending_bits;
    endcase
    return wm & MODE_MASK;
  endfunction

  function automatic clause_t clear_clause(input logic [8:0] wm);
    clause_t c;
    c.phase         = PH_BETWEEN;
    c.class_select  = '0;
    c.operator_code = OP_ADD;
    c.pending_bits  = '0;
    c.working_mode  = wm;
    return c;
  endfunction

endpackage

// ----- sv/cscp_step.sv -----
module cscp_step import cscp_pkg::*; (
  input  clause_t    cur,
  input  logic [7:0] ch,
  output clause_t    nxt,
  output logic       syn_err
);

  logic [8:0] cls;
  logic [8:0] prm;

  always_comb begin
    case (ch)
      8'h75:   cls = 9'o700;  // u
      8'h67:   cls = 9'o070;  // g
      8'h6f:   cls = 9'o007;  // o
      8'h61:   cls = 9'o777;  // a
      default: cls = 9'o000;
    endcase
    case (ch)
      8'h72:   prm = 9'o444;  // r
      8'h77:   prm = 9'o222;  // w
      8'h78:   prm = 9'o111;  // x
      default: prm = 9'o000;
    endcase
  end

  always_comb begin
    nxt     = cur;
    syn_err = 1'b0;
    case (cur.phase)
      PH_BETWEEN: begin
        if (ch == 8'h2c) begin
          nxt = cur;
        end else if (cls != '0) begin
          nxt.class_select = cls;
          nxt.phase        = PH_CLASSES;
        end else begin
          syn_err = 1'b1;
        end
      end
      PH_CLASSES: begin
        if (cls != '0) begin
          nxt.class_select = cur.class_select | cls;
        end else if (ch inside {8'h2b, 8'h2d, 8'h3d}) begin
          nxt.operator_code = (ch == 8'h2b) ? OP_ADD : (ch == 8'h2d) ? OP_SUB : OP_SET;
          nxt.pending_bits  = '0;
          nxt.phase         = PH_PERMS;
        end else begin
          syn_err = 1'b1;
        end
      end
      PH_PERMS: begin
        if (prm != '0) begin
          nxt.pending_bits = cur.pending_bits | (prm & cur.class_select);
        end else if (ch == 8'h2c) begin
          nxt = clear_clause(fold_clause(cur));
        end else begin
          syn_err = 1'b1;
        end
      end
      default: begin
        syn_err = 1'b1;
      end
    endcase
  end

endmodule

// ----- sv/chmod_symbolic_clause_parser_core.sv -----
// channel | dir | handshake             | payload
// cmd     | in  | cmd_valid / cmd_ready | cmd (cmd_t): ch, first, last, start_mode
// res     | out | res_valid / res_ready | res (res_t): new_mode, failed
//
// One character beat per cycle while cmd_ready is high; the parse state updates
// at the edge that accepts the beat, and a beat with last loads the result register.
// A result appears in the cycle after its last character is accepted.
// cmd_ready is low only while a result sits unaccepted in the result register.
// rst (synchronous) clears the parse state, the character count and res_valid.
module chmod_symbolic_clause_parser_core import cscp_pkg::*; #(
  parameter int MAX_COMMAND_LENGTH = MAX_COMMAND_LENGTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int CW = $clog2(MAX_COMMAND_LENGTH + 2);
  localparam logic [CW-1:0] MAX_LEN = CW'(MAX_COMMAND_LENGTH);

  clause_t       clause, clause_next;
  logic [8:0]    original_mode, original_mode_next;
  logic          error_seen, error_seen_next;
  logic [CW-1:0] char_count, char_count_next;
  res_t          res_next;

  clause_t       base, stepped;
  logic          syn_err;
  logic [CW-1:0] cnt_base, cnt_inc;
  logic          err_pre, err_post, err_fin;
  logic [8:0]    wm_fin;
  logic          take;

  assign cmd_ready = !res_valid || res_ready;
  assign take      = cmd_valid && cmd_ready;

  always_comb begin
    base               = cmd.first ? clear_clause(cmd.start_mode & MODE_MASK) : clause;
    original_mode_next = cmd.first ? (cmd.start_mode & MODE_MASK) : original_mode;
    cnt_base           = cmd.first ? '0 : char_count;
    cnt_inc            = (cnt_base <= MAX_LEN) ? cnt_base + CW'(1) : cnt_base;
    err_pre            = (cmd.first ? 1'b0 : error_seen) || (cnt_inc > MAX_LEN);
  end

  cscp_step u_step (
    .cur     (base),
    .ch      (cmd.ch),
    .nxt     (stepped),
    .syn_err (syn_err)
  );

  always_comb begin
    clause_next     = err_pre ? base : stepped;
    err_post        = err_pre || syn_err;
    error_seen_next = err_post;
    char_count_next = cnt_inc;

    // end of command: close an open clause, reject a clause still missing its operator
    err_fin = err_post || (clause_next.phase == PH_CLASSES);
    wm_fin  = (clause_next.phase == PH_PERMS) ? fold_clause(clause_next)
                                              : clause_next.working_mode;
    res_next.new_mode = err_fin ? original_mode_next : wm_fin;
    res_next.failed   = err_fin;

    if (cmd.last) begin
      clause_next     = clear_clause(original_mode_next);
      error_seen_next = 1'b0;
      char_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clause        <= clear_clause('0);
      original_mode <= '0;
      error_seen    <= 1'b0;
      char_count    <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (take) begin
        clause        <= clause_next;
        original_mode <= original_mode_next;
        error_seen    <= error_seen_next;
        char_count    <= char_count_next;
      end
      if (take && cmd.last) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && cmd.last) begin
      res <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_res_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(cmd_valid && cmd_ready && cmd.last))
    else $error("result beat without a last character");

  a_no_res_midcmd: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && !cmd.last && (!res_valid || res_ready)) |=> !res_valid)
    else $error("result beat raised by a non-last character");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    char_count <= MAX_LEN + CW'(1))
    else $error("character count beyond saturation");

  a_cmd_clean: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && cmd.last) |=>
      (!error_seen && char_count == '0 && clause.phase == PH_BETWEEN))
    else $error("parse state not cleared after a command");
`endif

endmodule
